// ----- src/brl_pkg.sv -----
// Shared types and constants for the line rasterizer.
// Used by the front end, the item queue, the step engine and the top level.
package brl_pkg;

   localparam int COORD_BITS_DEFAULT  = 12;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int CFG_ADDR_BITS = 4;
   localparam int CFG_DATA_BITS = 32;
   localparam int OFFSET_BITS   = 12;
   localparam int STRIDE_BITS   = 16;
   localparam int CHAN_BITS     = 8;
   localparam int COLOR_BITS    = 3 * CHAN_BITS;
   localparam int ADDR_BITS     = 32;
   localparam int WORD_BITS     = 32;
   localparam int HALF_BITS     = WORD_BITS / 2;

   localparam int RED_SHIFT_565   = 11;
   localparam int GREEN_SHIFT_565 = 5;
   // log2 of bytes per pixel in each mode
   localparam int SHIFT_BGRX32 = 2;
   localparam int SHIFT_RGB565 = 1;

   typedef enum logic [1:0] {
      REG_X_OFFSET    = 2'd0,
      REG_Y_OFFSET    = 2'd1,
      REG_LINE_STRIDE = 2'd2,
      REG_PIXEL_MODE  = 2'd3
   } reg_index_type;

   typedef enum logic {
      MODE_BGRX32 = 1'b0,
      MODE_RGB565 = 1'b1
   } pixel_mode_type;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_STEP = 1'b1
   } item_kind_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] x_offset;
      logic [OFFSET_BITS-1:0] y_offset;
      logic [STRIDE_BITS-1:0] line_stride;
      pixel_mode_type         pixel_mode;
   } cfg_type;

   // queue entry: kind, steep, major start, major stop, minor start,
   // minor direction, major delta, minor delta, color
   function automatic int entry_bits(input int coord_bits);
      return 5 * coord_bits + COLOR_BITS + 3;
   endfunction

   function automatic int req_data_bits(input int coord_bits);
      return ((4 * coord_bits + COLOR_BITS + 7) / 8) * 8;
   endfunction

   function automatic int rsp_data_bits(input int coord_bits);
      return ((2 * coord_bits + ADDR_BITS + WORD_BITS + 7) / 8) * 8;
   endfunction

endpackage

// ----- src/brl_front.sv -----
// Front end: unpacks request items and sets up line commands
// (major axis, endpoint order, deltas). Depends on brl_pkg.
module brl_front #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   input  logic [brl_pkg::req_data_bits(COORD_BITS)-1:0]  req_tdata,
   input  logic                                           req_tuser,
   output logic                                           q_wr_valid,
   input  logic                                           q_wr_ready,
   output logic [brl_pkg::entry_bits(COORD_BITS)-1:0]     q_wr_data
);

   localparam int C  = COORD_BITS;
   localparam int CB = brl_pkg::CHAN_BITS;

   logic [C-1:0]  xs, ys, xe, ye;
   logic [CB-1:0] red, green, blue;
   logic [C-1:0]  adx, ady;
   logic          x_desc, y_desc, steep, swap;
   logic [C-1:0]  mj0, mj1, mn0, mn1, dmaj, dmin;
   logic          minor_down;

   assign xs    = req_tdata[C-1:0];
   assign ys    = req_tdata[2*C-1:C];
   assign xe    = req_tdata[3*C-1:2*C];
   assign ye    = req_tdata[4*C-1:3*C];
   assign red   = req_tdata[4*C+CB-1:4*C];
   assign green = req_tdata[4*C+2*CB-1:4*C+CB];
   assign blue  = req_tdata[4*C+3*CB-1:4*C+2*CB];

   always_comb begin
      x_desc = xs > xe;
      y_desc = ys > ye;
      adx    = x_desc ? xs - xe : xe - xs;
      ady    = y_desc ? ys - ye : ye - ys;
      steep  = !(ady < adx);
      // order the endpoints so the major coordinate counts up
      swap   = steep ? y_desc : x_desc;
      if (steep) begin
         mj0 = swap ? ye : ys;
         mj1 = swap ? ys : ye;
         mn0 = swap ? xe : xs;
         mn1 = swap ? xs : xe;
         dmaj = ady;
         dmin = adx;
      end else begin
         mj0 = swap ? xe : xs;
         mj1 = swap ? xs : xe;
         mn0 = swap ? ye : ys;
         mn1 = swap ? ys : ye;
         dmaj = adx;
         dmin = ady;
      end
      minor_down = mn1 < mn0;
   end

   assign q_wr_data  = {red, green, blue, dmin, dmaj, minor_down, mn0, mj1, mj0, steep,
                        req_tuser};
   assign q_wr_valid = req_tvalid;
   assign req_tready = q_wr_ready;

endmodule

// ----- src/brl_queue.sv -----
// Small register queue between the front end and the step engine.
// Depends on brl_pkg for its default depth.
module brl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = brl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push, pop;

   assign wr_ready = count_ff != CNT_BITS'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- src/brl_back.sv -----
// Step engine: holds the line state, runs one Bresenham step per tick and
// forms pixel word and byte address over three stages. Depends on brl_pkg.
module brl_back #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  brl_pkg::cfg_type                               cfg,
   input  logic                                           q_rd_valid,
   output logic                                           q_rd_ready,
   input  logic [brl_pkg::entry_bits(COORD_BITS)-1:0]     q_rd_data,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   output logic [brl_pkg::rsp_data_bits(COORD_BITS)-1:0]  rsp_tdata,
   output logic                                           rsp_tlast
);

   localparam int C        = COORD_BITS;
   localparam int ERR_BITS = C + 3;
   localparam int SUM_BITS = ((C > brl_pkg::OFFSET_BITS) ? C : brl_pkg::OFFSET_BITS) + 1;
   localparam int PROD_BITS = SUM_BITS + brl_pkg::STRIDE_BITS;
   localparam int AB = brl_pkg::ADDR_BITS;
   localparam int WB = brl_pkg::WORD_BITS;
   localparam int HB = brl_pkg::HALF_BITS;
   localparam int CB = brl_pkg::CHAN_BITS;
   localparam int RSP_BITS = brl_pkg::rsp_data_bits(COORD_BITS);
   localparam logic signed [ERR_BITS-1:0] ERR_ZERO = '0;

   // queue entry fields
   logic [brl_pkg::COLOR_BITS-1:0] q_color;
   logic [C-1:0]                   q_dmin, q_dmaj, q_mn0, q_mj1, q_mj0;
   logic                           q_down, q_steep, q_kind;

   assign {q_color, q_dmin, q_dmaj, q_down, q_mn0, q_mj1, q_mj0, q_steep, q_kind} = q_rd_data;

   // line state
   logic                           active_ff, active_in;
   logic                           steep_ff, minor_down_ff;
   logic [C-1:0]                   major_pos_ff, minor_pos_ff, major_stop_ff;
   logic [C-1:0]                   delta_major_ff, delta_minor_ff;
   logic signed [ERR_BITS-1:0]     error_term_ff;
   logic [brl_pkg::COLOR_BITS-1:0] line_color_ff;

   logic                       advance, take, is_step, emit;
   logic signed [ERR_BITS-1:0] err_init, err_next, dmaj2, dmin2;
   logic [C-1:0]               major_next, minor_next;
   logic [C-1:0]               px, py;
   logic [CB-1:0]              red, green, blue;
   logic [HB-1:0]              word565;
   logic [WB-1:0]              word;

   // pipeline registers
   logic            s1_valid_ff, s1_last_ff;
   logic [C-1:0]    s1_px_ff, s1_py_ff;
   logic [WB-1:0]   s1_word_ff;
   logic            s2_valid_ff, s2_last_ff;
   logic [C-1:0]    s2_px_ff, s2_py_ff;
   logic [WB-1:0]   s2_word_ff;
   logic [AB-1:0]   s2_xpart_ff, s2_xpart_in, s2_ypart_ff, s2_ypart_in;
   logic            out_valid_ff, out_last_ff;
   logic [C-1:0]    out_px_ff, out_py_ff;
   logic [WB-1:0]   out_word_ff;
   logic [AB-1:0]   out_addr_ff;
   logic [SUM_BITS-1:0]  x_sum, y_sum;
   logic [PROD_BITS-1:0] y_prod;

   // the whole pipeline moves whenever the output slot frees up
   assign advance    = !out_valid_ff || rsp_tready;
   assign q_rd_ready = advance;
   assign take       = q_rd_valid && advance;
   assign is_step    = brl_pkg::item_kind_type'(q_kind) == brl_pkg::KIND_STEP;
   assign emit       = take && is_step && active_ff;

   always_comb begin
      err_init   = ERR_BITS'({q_dmin, 1'b0}) - ERR_BITS'(q_dmaj);
      dmaj2      = ERR_BITS'({delta_major_ff, 1'b0});
      dmin2      = ERR_BITS'({delta_minor_ff, 1'b0});
      err_next   = error_term_ff + dmin2;
      minor_next = minor_pos_ff;
      if (error_term_ff > ERR_ZERO) begin
         err_next   = error_term_ff + dmin2 - dmaj2;
         minor_next = minor_down_ff ? minor_pos_ff - C'(1) : minor_pos_ff + C'(1);
      end
      major_next = major_pos_ff + C'(1);
      active_in  = active_ff;
      if (take && !is_step) begin
         active_in = q_mj0 < q_mj1;
      end else if (emit) begin
         active_in = major_next < major_stop_ff;
      end
   end

   always_comb begin
      px    = steep_ff ? minor_pos_ff : major_pos_ff;
      py    = steep_ff ? major_pos_ff : minor_pos_ff;
      red   = line_color_ff[3*CB-1:2*CB];
      green = line_color_ff[2*CB-1:CB];
      blue  = line_color_ff[CB-1:0];
      // components are not narrowed: overlapping bits simply OR together
      word565 = (HB'(red) << brl_pkg::RED_SHIFT_565) |
                (HB'(green) << brl_pkg::GREEN_SHIFT_565) | HB'(blue);
      case (cfg.pixel_mode)
         brl_pkg::MODE_RGB565: word = WB'(word565);
         default:              word = WB'(line_color_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && !is_step) begin
         steep_ff       <= q_steep;
         major_pos_ff   <= q_mj0;
         major_stop_ff  <= q_mj1;
         minor_pos_ff   <= q_mn0;
         minor_down_ff  <= q_down;
         delta_major_ff <= q_dmaj;
         delta_minor_ff <= q_dmin;
         error_term_ff  <= err_init;
         line_color_ff  <= q_color;
      end else if (emit) begin
         major_pos_ff  <= major_next;
         minor_pos_ff  <= minor_next;
         error_term_ff <= err_next;
      end
   end

   // stage 2: split address into the x term and the y * stride term
   always_comb begin
      x_sum  = SUM_BITS'(s1_px_ff) + SUM_BITS'(cfg.x_offset);
      y_sum  = SUM_BITS'(s1_py_ff) + SUM_BITS'(cfg.y_offset);
      y_prod = PROD_BITS'(y_sum) * PROD_BITS'(cfg.line_stride);
      case (cfg.pixel_mode)
         brl_pkg::MODE_RGB565: s2_xpart_in = AB'(x_sum) << brl_pkg::SHIFT_RGB565;
         default:              s2_xpart_in = AB'(x_sum) << brl_pkg::SHIFT_BGRX32;
      endcase
      s2_ypart_in = AB'(y_prod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= emit;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_px_ff    <= px;
         s1_py_ff    <= py;
         s1_word_ff  <= word;
         s1_last_ff  <= !(major_next < major_stop_ff);
         s2_px_ff    <= s1_px_ff;
         s2_py_ff    <= s1_py_ff;
         s2_word_ff  <= s1_word_ff;
         s2_last_ff  <= s1_last_ff;
         s2_xpart_ff <= s2_xpart_in;
         s2_ypart_ff <= s2_ypart_in;
         out_px_ff   <= s2_px_ff;
         out_py_ff   <= s2_py_ff;
         out_word_ff <= s2_word_ff;
         out_last_ff <= s2_last_ff;
         out_addr_ff <= s2_xpart_ff + s2_ypart_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = RSP_BITS'({out_word_ff, out_addr_ff, out_py_ff, out_px_ff});

endmodule

// ----- src/bresenham_line_rasterizer.sv -----
// Line rasterizer top level: register port, front end, item queue, step engine.
// A step item's pixel passes the s1, s2 and output registers on its way to rsp.
// Throughput: one item per cycle unless rsp stalls, one pixel per step tick while a
// line is open; the queue and the three step-engine stages each pass one per cycle.
// Reset: synchronous; clears the registers, the queue, the pipeline and the open line.
// Depends on brl_pkg, brl_front, brl_queue and brl_back.
module bresenham_line_rasterizer #(
   parameter int COORD_BITS  = brl_pkg::COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = brl_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   // x_start, y_start, x_end, y_end, red, green, blue
   input  logic [brl_pkg::req_data_bits(COORD_BITS)-1:0]  req_tdata,
   // kind
   input  logic                                           req_tuser,
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   // pixel_x, pixel_y, byte_address, pixel_word
   output logic [brl_pkg::rsp_data_bits(COORD_BITS)-1:0]  rsp_tdata,
   output logic                                           rsp_tlast,
   input  logic                                           csr_psel,
   input  logic                                           csr_penable,
   input  logic                                           csr_pwrite,
   input  logic [brl_pkg::CFG_ADDR_BITS-1:0]              csr_paddr,
   input  logic [brl_pkg::CFG_DATA_BITS-1:0]              csr_pwdata,
   output logic [brl_pkg::CFG_DATA_BITS-1:0]              csr_prdata,
   output logic                                           csr_pready
);

   localparam int ENTRY_BITS = brl_pkg::entry_bits(COORD_BITS);
   localparam int DB = brl_pkg::CFG_DATA_BITS;

   brl_pkg::cfg_type       cfg_ff, cfg_in;
   brl_pkg::reg_index_type csr_index;
   logic                   csr_write;

   logic                  q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
   logic [ENTRY_BITS-1:0] q_wr_data, q_rd_data;

   assign csr_pready = 1'b1;
   assign csr_index  = brl_pkg::reg_index_type'(csr_paddr[brl_pkg::CFG_ADDR_BITS-1:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            brl_pkg::REG_X_OFFSET:
               cfg_in.x_offset = csr_pwdata[brl_pkg::OFFSET_BITS-1:0];
            brl_pkg::REG_Y_OFFSET:
               cfg_in.y_offset = csr_pwdata[brl_pkg::OFFSET_BITS-1:0];
            brl_pkg::REG_LINE_STRIDE:
               cfg_in.line_stride = csr_pwdata[brl_pkg::STRIDE_BITS-1:0];
            brl_pkg::REG_PIXEL_MODE:
               cfg_in.pixel_mode = brl_pkg::pixel_mode_type'(csr_pwdata[0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         brl_pkg::REG_X_OFFSET:    csr_prdata = DB'(cfg_ff.x_offset);
         brl_pkg::REG_Y_OFFSET:    csr_prdata = DB'(cfg_ff.y_offset);
         brl_pkg::REG_LINE_STRIDE: csr_prdata = DB'(cfg_ff.line_stride);
         brl_pkg::REG_PIXEL_MODE:  csr_prdata = DB'(cfg_ff.pixel_mode);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   brl_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_wr_valid (q_wr_valid),
      .q_wr_ready (q_wr_ready),
      .q_wr_data  (q_wr_data)
   );

   brl_queue #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_data  (q_wr_data),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_data  (q_rd_data)
   );

   brl_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_rd_valid (q_rd_valid),
      .q_rd_ready (q_rd_ready),
      .q_rd_data  (q_rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/brl_checker.sv -----
// Port-level checks for the line rasterizer, bound to the top level.
// Depends on brl_pkg for the port widths.
module brl_checker #(
   parameter int COORD_BITS = brl_pkg::COORD_BITS_DEFAULT
) (
   input logic                                           clock,
   input logic                                           reset,
   input logic                                           rsp_tvalid,
   input logic                                           rsp_tready,
   input logic [brl_pkg::rsp_data_bits(COORD_BITS)-1:0]  rsp_tdata,
   input logic                                           rsp_tlast,
   input logic                                           csr_pready
);

   localparam int WORD_LSB = 2 * COORD_BITS + brl_pkg::ADDR_BITS;
   localparam int WORD_MSB = WORD_LSB + brl_pkg::WORD_BITS - 1;
   localparam int TOP_LSB  = WORD_LSB + brl_pkg::COLOR_BITS;

   // no pixel may be left over from before a reset
   a_reset_drains: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // a waiting pixel holds still
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp item changed while stalled");

   // neither pixel format uses the top byte of the word
   a_word_top: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[WORD_MSB:TOP_LSB] == '0)
      else $error("pixel_word top byte not zero");

   a_pready: assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("csr_pready low");

endmodule

bind bresenham_line_rasterizer brl_checker #(
   .COORD_BITS (COORD_BITS)
) u_brl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .csr_pready (csr_pready)
);

// ----- dv/bresenham_line_rasterizer_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for bresenham_line_rasterizer: stream items in, pixels out.
// Uses brl_pkg for register, mode and item kind codes; needs only the RTL to build.
module bresenham_line_rasterizer_tb;

   localparam int COORD_W     = brl_pkg::COORD_BITS_DEFAULT;
   localparam int REQ_W       = brl_pkg::req_data_bits(COORD_W);
   localparam int RSP_W       = brl_pkg::rsp_data_bits(COORD_W);
   localparam int COORD_MAX   = (1 << COORD_W) - 1;
   localparam int LONG_HOLD   = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int ITEM_TARGET = 500;

   typedef struct packed {
      logic [COORD_W-1:0]            pixel_x;
      logic [COORD_W-1:0]            pixel_y;
      logic [brl_pkg::ADDR_BITS-1:0] byte_address;
      logic [brl_pkg::WORD_BITS-1:0] pixel_word;
      logic                          last_pixel;
   } pixel_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   // x_start, y_start, x_end, y_end, red, green, blue
   logic [REQ_W-1:0]                  req_tdata = '0;
   // kind
   brl_pkg::item_kind_type            req_tuser = brl_pkg::KIND_LOAD;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   // pixel_x, pixel_y, byte_address, pixel_word
   logic [RSP_W-1:0]                  rsp_tdata;
   logic                              rsp_tlast;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [brl_pkg::CFG_ADDR_BITS-1:0] csr_paddr = '0;
   logic [brl_pkg::CFG_DATA_BITS-1:0] csr_pwdata = '0;
   logic [brl_pkg::CFG_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   bresenham_line_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // shadow of the block: registers and the open line
   brl_pkg::cfg_type              cfg_shadow = '0;
   logic                          line_open = 1'b0;
   logic                          line_steep = 1'b0;
   logic                          minor_down = 1'b0;
   logic [COORD_W-1:0]            major_at = '0;
   logic [COORD_W-1:0]            minor_at = '0;
   logic [COORD_W-1:0]            major_last = '0;
   logic [COORD_W:0]              span_major = '0;
   logic [COORD_W:0]              span_minor = '0;
   int                            err_acc = 0;
   logic [brl_pkg::COLOR_BITS-1:0] line_rgb = '0;

   pixel_type expected_pixels[$];
   pixel_type seen_pixel;
   pixel_type want_pixel;

   int  fail_count = 0;
   int  items_sent = 0;
   int  lines_loaded = 0;
   int  pixels_checked = 0;
   int  csr_writes = 0;
   int  quiet_cycles = 0;
   bit  tx_idle = 1'b0;
   bit  rx_idle = 1'b0;
   bit  hold_pending = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int clamp_coord(input int v);
      return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
   endfunction

   function automatic logic [REQ_W-1:0] pack_line(input int x0, input int y0, input int x1,
                                                  input int y1, input int r, input int g,
                                                  input int b);
      return {8'(b), 8'(g), 8'(r), 12'(y1), 12'(x1), 12'(y0), 12'(x0)};
   endfunction

   // Advance the shadow by one accepted item; return 1 if the item is a load
   // or a tick that yields a pixel.
   function automatic bit rasterize_item(input brl_pkg::item_kind_type kind,
                                         input logic [REQ_W-1:0] data);
      logic [COORD_W-1:0] xs, ys, xe, ye, tmp, minor_end, px, py;
      logic [COORD_W:0]   dx, dy;
      logic [31:0]        word565;
      int                 shift;
      pixel_type          pix;
      if (kind == brl_pkg::KIND_LOAD) begin
         xs = data[11:0];
         ys = data[23:12];
         xe = data[35:24];
         ye = data[47:36];
         dx = {1'b0, (xs > xe) ? xs - xe : xe - xs};
         dy = {1'b0, (ys > ye) ? ys - ye : ye - ys};
         line_steep = !(dy < dx);
         // put the lower major coordinate first
         if ((!line_steep && xs > xe) || (line_steep && ys > ye)) begin
            tmp = xs; xs = xe; xe = tmp;
            tmp = ys; ys = ye; ye = tmp;
         end
         major_at   = line_steep ? ys : xs;
         major_last = line_steep ? ye : xe;
         minor_at   = line_steep ? xs : ys;
         minor_end  = line_steep ? xe : ye;
         span_major = {1'b0, major_last - major_at};
         minor_down = minor_end < minor_at;
         span_minor = {1'b0, minor_down ? minor_at - minor_end : minor_end - minor_at};
         err_acc    = 2 * int'(span_minor) - int'(span_major);
         line_open  = major_at < major_last;
         line_rgb   = {data[55:48], data[63:56], data[71:64]};
         lines_loaded++;
         return 1'b1;
      end
      if (!line_open)
         return 1'b0;
      px = line_steep ? minor_at : major_at;
      py = line_steep ? major_at : minor_at;
      shift = (cfg_shadow.pixel_mode == brl_pkg::MODE_RGB565) ? brl_pkg::SHIFT_RGB565
                                                               : brl_pkg::SHIFT_BGRX32;
      pix.pixel_x = px;
      pix.pixel_y = py;
      pix.byte_address = ((32'(px) + 32'(cfg_shadow.x_offset)) << shift)
                       + (32'(py) + 32'(cfg_shadow.y_offset)) * 32'(cfg_shadow.line_stride);
      word565 = (32'(line_rgb[23:16]) << brl_pkg::RED_SHIFT_565)
              | (32'(line_rgb[15:8]) << brl_pkg::GREEN_SHIFT_565)
              | 32'(line_rgb[7:0]);
      pix.pixel_word = (cfg_shadow.pixel_mode == brl_pkg::MODE_RGB565)
                       ? (word565 & 32'h0000_ffff) : {8'h00, line_rgb};
      if (err_acc > 0) begin
         minor_at = minor_down ? minor_at - COORD_W'(1) : minor_at + COORD_W'(1);
         err_acc  = err_acc - 2 * int'(span_major);
      end
      err_acc   = err_acc + 2 * int'(span_minor);
      major_at  = major_at + COORD_W'(1);
      line_open = major_at < major_last;
      pix.last_pixel = !line_open;
      expected_pixels.push_back(pix);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] pixel %0d: %s got 0x%0h expected 0x%0h",
               $realtime, pixels_checked, what, got, want);
      fail_count++;
   endtask

   task automatic send_item(input brl_pkg::item_kind_type kind, input logic [REQ_W-1:0] data);
      int gap;
      gap = tx_idle ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      if (rasterize_item(kind, data))
         items_sent++;
   endtask

   task automatic load_line(input int x0, input int y0, input int x1, input int y1,
                            input int r, input int g, input int b);
      send_item(brl_pkg::KIND_LOAD, pack_line(x0, y0, x1, y1, r, g, b));
   endtask

   // tick payload is don't-care; fill it with noise
   task automatic step_line(input int count);
      repeat (count)
         send_item(brl_pkg::KIND_STEP, REQ_W'({$urandom, $urandom, $urandom}));
   endtask

   // drop valid, wait for every pending pixel, then cover loads still in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_register(input brl_pkg::reg_index_type idx, input logic [31:0] value);
      settle();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         brl_pkg::REG_X_OFFSET:
            cfg_shadow.x_offset    = value[brl_pkg::OFFSET_BITS-1:0];
         brl_pkg::REG_Y_OFFSET:
            cfg_shadow.y_offset    = value[brl_pkg::OFFSET_BITS-1:0];
         brl_pkg::REG_LINE_STRIDE:
            cfg_shadow.line_stride = value[brl_pkg::STRIDE_BITS-1:0];
         brl_pkg::REG_PIXEL_MODE:
            cfg_shadow.pixel_mode  = brl_pkg::pixel_mode_type'(value[0]);
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic apply_settings(input int xo, input int yo, input int stride,
                                 input brl_pkg::pixel_mode_type mode);
      write_register(brl_pkg::REG_X_OFFSET, 32'(xo));
      write_register(brl_pkg::REG_Y_OFFSET, 32'(yo));
      write_register(brl_pkg::REG_LINE_STRIDE, 32'(stride));
      write_register(brl_pkg::REG_PIXEL_MODE, 32'(mode));
   endtask

   // ticks before any line and on an empty line produce nothing
   task automatic test_idle_ticks();
      step_line(1);
      load_line(2000, 17, 2000, 17, 1, 2, 3);
      step_line(1);
   endtask

   task automatic test_line_shapes();
      tx_idle = 1'b1;
      rx_idle = 1'b1;
      // shallow, right to left, endpoints at the field extremes
      load_line(COORD_MAX, COORD_MAX, 0, COORD_MAX - 5, 255, 255, 255);
      step_line(3);
      // replace the open line with a steep one
      load_line(0, 0, 3, COORD_MAX, 0, 0, 0);
      step_line(3);
      // diagonal counts as steep; minor axis runs down after the swap
      load_line(5, 10, 8, 7, 18, 52, 86);
      step_line(3);
      // run to the last pixel, then one idle tick
      load_line(100, 200, 103, 201, 170, 85, 15);
      step_line(4);
   endtask

   task automatic test_register_extremes();
      apply_settings(COORD_MAX, COORD_MAX, 65535, brl_pkg::MODE_RGB565);
      // 5-6-5 packing of full-range components
      load_line(COORD_MAX, 10, COORD_MAX - 4, 12, 255, 128, 255);
      step_line(2);
      // switch mode with the line still open
      write_register(brl_pkg::REG_PIXEL_MODE, 32'(brl_pkg::MODE_BGRX32));
      step_line(3);
   endtask

   task automatic test_output_backpressure();
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      hold_pending = 1'b1;
      load_line(50, 60, 110, 70, 9, 99, 199);
      step_line(60);
      settle();
   endtask

   task automatic random_line();
      int pick, len, off, x0, y0, x1, y1, n, ticks;
      pick = $urandom_range(0, 19);
      len = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(13, 80) : $urandom_range(1, 12);
      x0 = (pick == 2) ? COORD_MAX * $urandom_range(0, 1) : $urandom_range(0, COORD_MAX);
      y0 = (pick == 3) ? COORD_MAX * $urandom_range(0, 1) : $urandom_range(0, COORD_MAX);
      off = $urandom_range(0, 2 * len);
      off = off - len;
      if ($urandom_range(0, 1)) begin
         x1 = clamp_coord($urandom_range(0, 1) ? x0 + len : x0 - len);
         y1 = clamp_coord(y0 + off);
      end else begin
         y1 = clamp_coord($urandom_range(0, 1) ? y0 + len : y0 - len);
         x1 = clamp_coord(x0 + off);
      end
      n = (x1 > x0) ? x1 - x0 : x0 - x1;
      if (((y1 > y0) ? y1 - y0 : y0 - y1) > n)
         n = (y1 > y0) ? y1 - y0 : y0 - y1;
      ticks = n + $urandom_range(0, 2);
      // now and then cut the line short and let the next load replace it
      if ($urandom_range(0, 7) == 0)
         ticks = $urandom_range(0, n);
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      load_line(x0, y0, x1, y1, $urandom_range(0, 255), $urandom_range(0, 255),
                $urandom_range(0, 255));
      step_line(ticks);
   endtask

   task automatic test_random_lines();
      int target;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: apply_settings(0, 0, 0, brl_pkg::MODE_BGRX32);
            1: apply_settings(COORD_MAX, COORD_MAX, 65535, brl_pkg::MODE_RGB565);
            default: apply_settings($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                                    $urandom_range(0, 65535),
                                    brl_pkg::pixel_mode_type'($urandom_range(0, 1)));
         endcase
         target = items_sent + (ITEM_TARGET - items_sent) / (5 - phase);
         while (items_sent < target)
            random_line();
      end
   endtask

   // result side: random stall per item, one long hold on request
   initial begin : rsp_side
      int stall;
      forever begin
         stall = rx_idle ? $urandom_range(0, 14) : 0;
         if (hold_pending) begin
            stall = LONG_HOLD;
            hold_pending = 1'b0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_pixel.pixel_x      = rsp_tdata[11:0];
         seen_pixel.pixel_y      = rsp_tdata[23:12];
         seen_pixel.byte_address = rsp_tdata[55:24];
         seen_pixel.pixel_word   = rsp_tdata[87:56];
         seen_pixel.last_pixel   = rsp_tlast;
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel at x", longint'(seen_pixel.pixel_x), 64'd0);
         end else begin
            want_pixel = expected_pixels.pop_front();
            if (seen_pixel.pixel_x !== want_pixel.pixel_x)
               report_mismatch("pixel_x", longint'(seen_pixel.pixel_x),
                               longint'(want_pixel.pixel_x));
            if (seen_pixel.pixel_y !== want_pixel.pixel_y)
               report_mismatch("pixel_y", longint'(seen_pixel.pixel_y),
                               longint'(want_pixel.pixel_y));
            if (seen_pixel.byte_address !== want_pixel.byte_address)
               report_mismatch("byte_address", longint'(seen_pixel.byte_address),
                               longint'(want_pixel.byte_address));
            if (seen_pixel.pixel_word !== want_pixel.pixel_word)
               report_mismatch("pixel_word", longint'(seen_pixel.pixel_word),
                               longint'(want_pixel.pixel_word));
            if (seen_pixel.last_pixel !== want_pixel.last_pixel)
               report_mismatch("last_pixel", longint'(seen_pixel.last_pixel),
                               longint'(want_pixel.last_pixel));
         end
         pixels_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("[%0t] no handshake for %0d cycles, %0d pixels outstanding",
                     $realtime, STALL_LIMIT, expected_pixels.size());
            $display("bresenham_line_rasterizer_tb failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_idle_ticks();
      test_line_shapes();
      test_register_extremes();
      test_output_backpressure();
      test_random_lines();
      settle();
      $display("ran %0d items over %0d lines, checked %0d pixels, %0d register writes",
               items_sent, lines_loaded, pixels_checked, csr_writes);
      $display("register settings included zero and full offsets and stride in both modes");
      if (fail_count == 0) begin
         $display("bresenham_line_rasterizer_tb passed");
      end else begin
         $display("bresenham_line_rasterizer_tb failed");
      end
      $finish;
   end

endmodule

// ----- bresenham_line_rasterizer.f -----
src/brl_pkg.sv
src/brl_front.sv
src/brl_queue.sv
src/brl_back.sv
src/bresenham_line_rasterizer.sv
src/brl_checker.sv
dv/bresenham_line_rasterizer_tb.sv
